// File: rtl/hrpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrpc_pkg: shared types and constants of the hue ramp pseudo-colour map
// Widths, register indexes, hue sectors and the small modulo-six reduction.
// ----------------------------------------------------------------------------
package hrpc_pkg;

	// Field and register widths
	localparam int IdxW     = 16;
	localparam int RangeW   = 16;
	localparam int CountW   = RangeW + 1;
	localparam int SatW     = 9;
	localparam int ByteW    = 8;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 16;

	// Hue: 256 units per sector, four sectors over the ramp -> index * 1024
	localparam int HueShift = 10;
	localparam int HueW     = IdxW + HueShift;
	localparam int FracW    = 8;
	localparam int SectW    = HueW - FracW;

	// Divider pipeline: two quotient bits per stage
	localparam int DivBitsPerStage = 2;
	localparam int DivStages       = HueW / DivBitsPerStage;

	// Fixed-point one for saturation (1.8) and for the 16-bit fraction products
	localparam logic [SatW-1:0]   SatOne  = 9'd256;
	localparam logic [CountW-1:0] ProdOne = 17'h10000;

	// Reset values of the registers
	localparam logic [RangeW-1:0] MinReset = 16'd0;
	localparam logic [RangeW-1:0] MaxReset = 16'd255;
	localparam logic [ByteW-1:0]  BriReset = 8'd255;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MIN_RANGE  = 2'd0,
		REG_MAX_RANGE  = 2'd1,
		REG_SATURATION = 2'd2,
		REG_BRIGHTNESS = 2'd3
	} cfg_reg_t;

	// HSV sectors, named after the colour at their start
	localparam logic [2:0] SectRed     = 3'd0;
	localparam logic [2:0] SectYellow  = 3'd1;
	localparam logic [2:0] SectGreen   = 3'd2;
	localparam logic [2:0] SectCyan    = 3'd3;
	localparam logic [2:0] SectBlue    = 3'd4;
	localparam logic [2:0] SectMagenta = 3'd5;

	// Derived configuration seen by the datapath
	typedef struct packed {
		logic [CountW-1:0] count;
		logic [SatW-1:0]   sat;
		logic [ByteW-1:0]  bri;
		logic              bad;
	} cfg_t;

	// Reduce the sector number modulo six: parity from bit 0, modulo three
	// from folding base-4 digits (4 is 1 mod 3), then join the two.
	function automatic logic [2:0] mod6(input logic [SectW-1:0] x);
		logic [4:0] s1;
		logic [2:0] s2;
		logic [2:0] s3;
		logic [1:0] m3;
		s1 = '0;
		for (int i = 0; i < SectW / 2; i++) begin
			s1 = s1 + 5'(x[2*i +: 2]);
		end
		s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
		s3 = 3'(s2[1:0]) + 3'(s2[2]);
		m3 = (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
		return (m3[0] == x[0]) ? {1'b0, m3} : 3'({1'b0, m3} + 3'd3);
	endfunction

endpackage
`default_nettype wire

// File: rtl/hrpc_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrpc_cfg: configuration registers
// Holds the four registers and the values derived from them at write time:
// ramp count, empty-ramp flag and saturation clamped to one.
// ----------------------------------------------------------------------------
module hrpc_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [hrpc_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [hrpc_pkg::CfgDataW-1:0]  cfg_data,
	output hrpc_pkg::cfg_t                      cfg
);

	logic [hrpc_pkg::RangeW-1:0] min_q;
	logic [hrpc_pkg::RangeW-1:0] max_q;
	logic [hrpc_pkg::CountW-1:0] count_q;
	logic                        bad_q;
	logic [hrpc_pkg::SatW-1:0]   sat_q;
	logic [hrpc_pkg::ByteW-1:0]  bri_q;

	logic [hrpc_pkg::RangeW-1:0] wr_range;
	logic [hrpc_pkg::SatW-1:0]   wr_sat;

	assign wr_range = cfg_data[hrpc_pkg::RangeW-1:0];
	assign wr_sat   = cfg_data[hrpc_pkg::SatW-1:0];

	// Write a register and refresh what depends on it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= hrpc_pkg::MinReset;
			max_q   <= hrpc_pkg::MaxReset;
			count_q <= {1'b0, hrpc_pkg::MaxReset} - {1'b0, hrpc_pkg::MinReset} + 17'd1;
			bad_q   <= 1'b0;
			sat_q   <= hrpc_pkg::SatOne;
			bri_q   <= hrpc_pkg::BriReset;
		end else if (cfg_we) begin
			unique case (hrpc_pkg::cfg_reg_t'(cfg_index))
				hrpc_pkg::REG_MIN_RANGE: begin
					min_q   <= wr_range;
					count_q <= {1'b0, max_q} - {1'b0, wr_range} + 17'd1;
					bad_q   <= max_q < wr_range;
				end
				hrpc_pkg::REG_MAX_RANGE: begin
					max_q   <= wr_range;
					count_q <= {1'b0, wr_range} - {1'b0, min_q} + 17'd1;
					bad_q   <= wr_range < min_q;
				end
				hrpc_pkg::REG_SATURATION: begin
					sat_q <= (wr_sat > hrpc_pkg::SatOne) ? hrpc_pkg::SatOne : wr_sat;
				end
				hrpc_pkg::REG_BRIGHTNESS: begin
					bri_q <= cfg_data[hrpc_pkg::ByteW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.count = count_q;
	assign cfg.sat   = sat_q;
	assign cfg.bri   = bri_q;
	assign cfg.bad   = bad_q;

endmodule
`default_nettype wire

// File: rtl/hrpc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrpc_div: pipelined hue divider
// Restoring division of index * 1024 by the ramp count, two quotient bits
// per stage, with a valid bit and a ready chain through every stage.
// ----------------------------------------------------------------------------
module hrpc_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [hrpc_pkg::IdxW-1:0]     index,
	input  wire logic [hrpc_pkg::CountW-1:0]   count,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [hrpc_pkg::HueW-1:0]          hue
);

	localparam int NS = hrpc_pkg::DivStages;

	// Partial remainder and a word that shifts dividend bits out and quotient bits in
	typedef struct packed {
		logic [hrpc_pkg::CountW-1:0] rem;
		logic [hrpc_pkg::HueW-1:0]   work;
	} div_state_t;

	function automatic div_state_t div_step(input div_state_t st,
		input logic [hrpc_pkg::CountW-1:0] d);
		logic [hrpc_pkg::CountW:0]   trial;
		logic [hrpc_pkg::CountW+1:0] diff;
		div_state_t                  nx;
		trial   = {st.rem, st.work[hrpc_pkg::HueW-1]};
		diff    = {1'b0, trial} - {2'b00, d};
		nx.work = {st.work[hrpc_pkg::HueW-2:0], ~diff[hrpc_pkg::CountW+1]};
		nx.rem  = diff[hrpc_pkg::CountW+1] ? trial[hrpc_pkg::CountW-1:0]
		                                   : diff[hrpc_pkg::CountW-1:0];
		return nx;
	endfunction

	logic       vld_s [NS];
	div_state_t st_s  [NS];
	div_state_t nxt   [NS];
	logic       rdy   [NS+1];
	div_state_t src;

	// Two division steps per stage
	always_comb begin
		for (int k = 0; k < NS; k++) begin
			if (k == 0) begin
				src.rem  = '0;
				src.work = {index, {hrpc_pkg::HueShift{1'b0}}};
			end else begin
				src = st_s[k-1];
			end
			nxt[k] = src;
			for (int b = 0; b < hrpc_pkg::DivBitsPerStage; b++) begin
				nxt[k] = div_step(nxt[k], count);
			end
		end
	end

	// A stage takes a new beat when it is empty or its successor moves
	always_comb begin
		rdy[NS] = out_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			rdy[k] = ~vld_s[k] | rdy[k+1];
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= (k == 0) ? in_valid : vld_s[k > 0 ? k - 1 : 0];
				end
			end
		end
	end

	// Advance stage data
	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			if (rdy[k]) begin
				st_s[k] <= nxt[k];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[NS-1];
	assign hue       = st_s[NS-1].work;

	// The final remainder is always below a nonzero divisor; an empty ramp can
	// wrap the count to zero, and its beats are forced black downstream
	a_rem_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && count != '0) |-> (st_s[NS-1].rem < count))
		else $error("divider remainder not below count");

endmodule
`default_nettype wire

// File: rtl/hrpc_hsv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrpc_hsv: hue to RGB conversion
// Three stages: sector and fraction products, component products, six-way
// select into the output register. Empty ramp forces black.
// ----------------------------------------------------------------------------
module hrpc_hsv (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [hrpc_pkg::HueW-1:0]     hue,
	input  wire hrpc_pkg::cfg_t                cfg,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [hrpc_pkg::ByteW-1:0]         red,
	output logic [hrpc_pkg::ByteW-1:0]         green,
	output logic [hrpc_pkg::ByteW-1:0]         blue,
	output logic                               bad_config
);

	localparam int BW = hrpc_pkg::ByteW;
	localparam int CW = hrpc_pkg::CountW;

	logic          vld_s1, vld_s2, vld_s3;
	logic          rdy1, rdy2, rdy3;
	logic [2:0]    sector_s1, sector_s2;
	logic [CW-1:0] fs_s1, gs_s1;
	logic [BW-1:0] p_s2, q_s2, t_s2;
	logic [BW-1:0] red_s3, green_s3, blue_s3;
	logic          bad_s3;

	logic [BW-1:0]        frac;
	logic [CW-1:0]        fs;
	logic [CW:0]          gs_full;
	logic [CW-1:0]        qn, tn;
	logic [CW+BW-1:0]     qprod, tprod;
	logic [BW+8:0]        pprod;
	logic [BW-1:0]        r_sel, g_sel, b_sel;

	// Ready chain: a stage moves when empty or its successor moves
	assign rdy3     = ~vld_s3 | out_ready;
	assign rdy2     = ~vld_s2 | rdy3;
	assign rdy1     = ~vld_s1 | rdy2;
	assign in_ready = rdy1;

	// Stage 1: sector and fraction times saturation
	assign frac    = hue[hrpc_pkg::FracW-1:0];
	assign fs      = CW'(frac) * CW'(cfg.sat);
	assign gs_full = (hrpc_pkg::SatOne - {1'b0, frac}) * cfg.sat;

	// Stage 2: scale by the value byte and keep the integer part
	assign qn    = hrpc_pkg::ProdOne - fs_s1;
	assign tn    = hrpc_pkg::ProdOne - gs_s1;
	assign qprod = cfg.bri * qn;
	assign tprod = cfg.bri * tn;
	assign pprod = cfg.bri * (hrpc_pkg::SatOne - cfg.sat);

	// Stage 3: six-way select
	always_comb begin
		unique case (sector_s2)
			hrpc_pkg::SectRed:     begin r_sel = cfg.bri; g_sel = t_s2;    b_sel = p_s2;    end
			hrpc_pkg::SectYellow:  begin r_sel = q_s2;    g_sel = cfg.bri; b_sel = p_s2;    end
			hrpc_pkg::SectGreen:   begin r_sel = p_s2;    g_sel = cfg.bri; b_sel = t_s2;    end
			hrpc_pkg::SectCyan:    begin r_sel = p_s2;    g_sel = q_s2;    b_sel = cfg.bri; end
			hrpc_pkg::SectBlue:    begin r_sel = t_s2;    g_sel = p_s2;    b_sel = cfg.bri; end
			hrpc_pkg::SectMagenta: begin r_sel = cfg.bri; g_sel = p_s2;    b_sel = q_s2;    end
			default:               begin r_sel = cfg.bri; g_sel = p_s2;    b_sel = q_s2;    end
		endcase
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				vld_s1 <= in_valid;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	// Advance stage data
	always_ff @(posedge clk) begin
		if (rdy1) begin
			sector_s1 <= hrpc_pkg::mod6(hue[hrpc_pkg::HueW-1:hrpc_pkg::FracW]);
			fs_s1     <= fs;
			gs_s1     <= gs_full[CW-1:0];
		end
		if (rdy2) begin
			sector_s2 <= sector_s1;
			p_s2      <= pprod[15:8];
			q_s2      <= qprod[23:16];
			t_s2      <= tprod[23:16];
		end
		if (rdy3) begin
			red_s3   <= cfg.bad ? '0 : r_sel;
			green_s3 <= cfg.bad ? '0 : g_sel;
			blue_s3  <= cfg.bad ? '0 : b_sel;
			bad_s3   <= cfg.bad;
		end
	end

	assign out_valid  = vld_s3;
	assign red        = red_s3;
	assign green      = green_s3;
	assign blue       = blue_s3;
	assign bad_config = bad_s3;

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (sector_s2 <= hrpc_pkg::SectMagenta))
		else $error("sector out of range");

	a_bad_black: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_config) |-> (red == '0 && green == '0 && blue == '0))
		else $error("empty ramp not black");

	a_grey_when_unsaturated: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !bad_config && cfg.sat == '0)
			|-> (red == cfg.bri && green == cfg.bri && blue == cfg.bri))
		else $error("zero saturation not grey");

endmodule
`default_nettype wire

// File: rtl/hue_ramp_pseudo_color_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hue_ramp_pseudo_color_top: hue ramp pseudo-colour map
// Maps a colour index to RGB bytes along a 240-degree hue ramp through a
// pipelined divider and an HSV to RGB stage.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  pix      pix_valid/pix_ready   color_index
//  rgb      rgb_valid/rgb_ready   red, green, blue, bad_config
//  cfg      cfg_we                cfg_index, cfg_data
//
//  One beat per cycle sustained while rgb_ready stays high; 13 divider stages at two
//  quotient bits each, then three colour stages.
//  Every stage has its own valid bit; a stalled output holds the last stage
//  while empty stages ahead of it keep filling.
//  Reset clears all valid bits and loads the register defaults.
//  Configuration writes take effect on the next cycle.
// ----------------------------------------------------------------------------
module hue_ramp_pseudo_color_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pix_valid,
	output logic                               pix_ready,
	input  wire logic [hrpc_pkg::IdxW-1:0]     color_index,
	output logic                               rgb_valid,
	input  wire logic                          rgb_ready,
	output logic [hrpc_pkg::ByteW-1:0]         red,
	output logic [hrpc_pkg::ByteW-1:0]         green,
	output logic [hrpc_pkg::ByteW-1:0]         blue,
	output logic                               bad_config,
	input  wire logic                          cfg_we,
	input  wire logic [hrpc_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [hrpc_pkg::CfgDataW-1:0] cfg_data
);

	hrpc_pkg::cfg_t             cfg;
	logic                       hue_valid;
	logic                       hue_ready;
	logic [hrpc_pkg::HueW-1:0]  hue;

	hrpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hrpc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_valid),
		.in_ready  (pix_ready),
		.index     (color_index),
		.count     (cfg.count),
		.out_valid (hue_valid),
		.out_ready (hue_ready),
		.hue       (hue)
	);

	hrpc_hsv u_hsv (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (hue_valid),
		.in_ready   (hue_ready),
		.hue        (hue),
		.cfg        (cfg),
		.out_valid  (rgb_valid),
		.out_ready  (rgb_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.bad_config (bad_config)
	);

endmodule
`default_nettype wire

// File: tb/sv/tb_hue_ramp_pseudo_color_top.sv
// ----------------------------------------------------------------------------
// tb_hue_ramp_pseudo_color_top: self-checking bench for the hue ramp map
// Walks a short table of directed pixels and register writes, then runs
// random phases. Each phase has its own ramp, saturation, brightness and
// idling pattern. Each accepted pixel gets an expected colour from the table
// or from an HSV model kept in the bench; each output beat is checked in order.
// ----------------------------------------------------------------------------
module tb_hue_ramp_pseudo_color_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hrpc_pkg::*;

	localparam int NumPhases   = 16;
	localparam int PhaseItems  = 125;
	localparam int PauseCycles = 20;
	localparam int EndCycles   = 40;
	localparam int HoldCycles  = 300;
	localparam int MaxPrinted  = 40;
	localparam int NumSteps    = 30;

	typedef struct packed {
		logic [ByteW-1:0] red;
		logic [ByteW-1:0] green;
		logic [ByteW-1:0] blue;
		logic             bad;
	} rgb_beat_t;

	typedef enum logic {ROW_PIX, ROW_REG} step_kind_t;

	typedef struct {
		step_kind_t        kind;
		cfg_reg_t          sel;
		logic [15:0]       value;
		bit                typed;
		rgb_beat_t         want;
	} step_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                pix_valid = 1'b0;
	logic                pix_ready;
	logic [IdxW-1:0]     color_index = '0;
	logic                rgb_valid;
	logic                rgb_ready = 1'b0;
	logic [ByteW-1:0]    red;
	logic [ByteW-1:0]    green;
	logic [ByteW-1:0]    blue;
	logic                bad_config;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	// Bench copy of the registers
	logic [RangeW-1:0] cur_min = MinReset;
	logic [RangeW-1:0] cur_max = MaxReset;
	logic [SatW-1:0]   cur_sat = SatOne;
	logic [ByteW-1:0]  cur_bri = BriReset;

	rgb_beat_t   pending_colours [$];
	int          mismatch_count = 0;
	int          beat_count = 0;
	int unsigned source_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	bit          hold_off_req = 1'b0;

	// Directed pixels under the reset ramp (four hue units per index,
	// 1024/256), then saturation, brightness and ramp extremes
	step_t steps [NumSteps] = '{
		'{ROW_PIX, REG_MIN_RANGE,  16'd0,     1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
		'{ROW_PIX, REG_MIN_RANGE,  16'd64,    1'b1, '{8'd255, 8'd255, 8'd0,   1'b0}},
		'{ROW_PIX, REG_MIN_RANGE,  16'd128,   1'b1, '{8'd0,   8'd255, 8'd0,   1'b0}},
		'{ROW_PIX, REG_MIN_RANGE,  16'd192,   1'b1, '{8'd0,   8'd255, 8'd255, 1'b0}},
		'{ROW_PIX, REG_MIN_RANGE,  16'd256,   1'b1, '{8'd0,   8'd0,   8'd255, 1'b0}},
		'{ROW_PIX, REG_MIN_RANGE,  16'd320,   1'b1, '{8'd255, 8'd0,   8'd255, 1'b0}},
		'{ROW_PIX, REG_MIN_RANGE,  16'd384,   1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
		'{ROW_PIX, REG_MIN_RANGE,  16'd32,    1'b0, '0},
		'{ROW_PIX, REG_MIN_RANGE,  16'd255,   1'b0, '0},
		'{ROW_PIX, REG_MIN_RANGE,  16'hFFFF,  1'b0, '0},
		'{ROW_REG, REG_SATURATION, 16'd0,     1'b0, '0},
		'{ROW_PIX, REG_MIN_RANGE,  16'd100,   1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
		'{ROW_REG, REG_SATURATION, 16'h01FF,  1'b0, '0},
		'{ROW_PIX, REG_MIN_RANGE,  16'd0,     1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
		'{ROW_REG, REG_SATURATION, 16'hFE80,  1'b0, '0},
		'{ROW_REG, REG_BRIGHTNESS, 16'd0,     1'b0, '0},
		'{ROW_PIX, REG_MIN_RANGE,  16'd777,   1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
		'{ROW_REG, REG_BRIGHTNESS, 16'd128,   1'b0, '0},
		'{ROW_PIX, REG_MIN_RANGE,  16'd200,   1'b0, '0},
		'{ROW_REG, REG_MIN_RANGE,  16'd100,   1'b0, '0},
		'{ROW_REG, REG_MAX_RANGE,  16'd99,    1'b0, '0},
		'{ROW_PIX, REG_MIN_RANGE,  16'd5,     1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
		'{ROW_PIX, REG_MIN_RANGE,  16'hFFFF,  1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
		'{ROW_REG, REG_MIN_RANGE,  16'd0,     1'b0, '0},
		'{ROW_REG, REG_MAX_RANGE,  16'd0,     1'b0, '0},
		'{ROW_PIX, REG_MIN_RANGE,  16'd1,     1'b0, '0},
		'{ROW_REG, REG_MAX_RANGE,  16'hFFFF,  1'b0, '0},
		'{ROW_PIX, REG_MIN_RANGE,  16'hFFFF,  1'b0, '0},
		'{ROW_REG, REG_MIN_RANGE,  16'hFFFF,  1'b0, '0},
		'{ROW_PIX, REG_MIN_RANGE,  16'hFFFF,  1'b0, '0}
	};

	hue_ramp_pseudo_color_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.color_index(color_index),
		.rgb_valid  (rgb_valid),
		.rgb_ready  (rgb_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.bad_config (bad_config),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// HSV colour of one index under the current registers
	function automatic rgb_beat_t hsv_colour(input logic [IdxW-1:0] idx);
		rgb_beat_t         c;
		longint unsigned   span;
		longint unsigned   hue;
		longint unsigned   frac;
		longint unsigned   sat;
		longint unsigned   val;
		longint unsigned   p;
		longint unsigned   q;
		longint unsigned   t;
		logic [2:0]        sector;
		c = '0;
		// Empty ramp: black and the flag
		if (cur_max < cur_min) begin
			c.bad = 1'b1;
			return c;
		end
		span = cur_max;
		span = span - cur_min + 1;
		hue = idx;
		hue = (hue << HueShift) / span;
		sector = 3'((hue >> FracW) % 6);
		frac = hue & 255;
		sat = (cur_sat > 256) ? 256 : cur_sat;
		val = cur_bri;
		p = (val * (256 - sat)) >> 8;
		q = (val * (65536 - frac * sat)) >> 16;
		t = (val * (65536 - (256 - frac) * sat)) >> 16;
		case (sector)
			SectRed: begin
				c.red = 8'(val); c.green = 8'(t); c.blue = 8'(p);
			end
			SectYellow: begin
				c.red = 8'(q); c.green = 8'(val); c.blue = 8'(p);
			end
			SectGreen: begin
				c.red = 8'(p); c.green = 8'(val); c.blue = 8'(t);
			end
			SectCyan: begin
				c.red = 8'(p); c.green = 8'(q); c.blue = 8'(val);
			end
			SectBlue: begin
				c.red = 8'(t); c.green = 8'(p); c.blue = 8'(val);
			end
			default: begin
				c.red = 8'(val); c.green = 8'(p); c.blue = 8'(q);
			end
		endcase
		return c;
	endfunction

	// Pick an index: mostly inside the ramp, some at sector starts, some anywhere
	function automatic logic [IdxW-1:0] pick_index();
		int unsigned span;
		int unsigned k;
		if (cur_max < cur_min)
			return IdxW'($urandom);
		span = int'(cur_max) - int'(cur_min) + 1;
		case ($urandom_range(9))
			0, 1: return IdxW'($urandom);
			2, 3: begin
				k = $urandom_range(7);
				return IdxW'((k * span + 3) / 4);
			end
			default: return IdxW'($urandom_range(span - 1));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= MaxPrinted)
			$display("ERROR at %0t beat %0d: %s got %0d want %0d", $time, beat_count, what,
				got, want);
	endtask

	// Offer one pixel beat and record its expected colour once accepted
	task automatic send_pixel(input logic [IdxW-1:0] idx, input bit typed,
			input rgb_beat_t want);
		while ($urandom_range(99) < source_idle_pct) begin
			pix_valid = 1'b0;
			@(negedge clk);
		end
		pix_valid = 1'b1;
		color_index = idx;
		@(posedge clk);
		while (!pix_ready)
			@(posedge clk);
		pending_colours.push_back(typed ? want : hsv_colour(idx));
		@(negedge clk);
	endtask

	// Drop valid, wait for every expected colour, then let the pipe settle
	task automatic drain_pipe(input int settle);
		pix_valid = 1'b0;
		while (pending_colours.size() != 0)
			@(posedge clk);
		@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t sel, input logic [CfgDataW-1:0] data);
		cfg_we = 1'b1;
		cfg_index = sel;
		cfg_data = data;
		case (sel)
			REG_MIN_RANGE:  cur_min = data;
			REG_MAX_RANGE:  cur_max = data;
			REG_SATURATION: cur_sat = data[SatW-1:0];
			REG_BRIGHTNESS: cur_bri = data[ByteW-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Set up the ramp, colour registers and idling pattern of one phase
	task automatic start_phase(input int ph);
		logic [CfgDataW-1:0] lo;
		logic [CfgDataW-1:0] hi;
		logic [CfgDataW-1:0] sat;
		logic [CfgDataW-1:0] bri;
		int                  top;
		drain_pipe(PauseCycles);
		lo = CfgDataW'($urandom);
		hi = CfgDataW'($urandom);
		sat = CfgDataW'($urandom);
		bri = CfgDataW'($urandom);
		if (ph == 0) begin
			lo = '0;
			hi = '1;
			sat = 16'd256;
			bri = 16'd255;
		end else if (ph == 1) begin
			lo = '1;
			hi = '0;
		end else if (ph == 2) begin
			lo = '0;
			hi = '0;
			sat = '0;
			bri = '1;
		end else begin
			case ($urandom_range(9))
				0, 1: ;
				2: hi = lo;
				3: begin
					if (lo == 0)
						lo = 1;
					hi = CfgDataW'($urandom_range(int'(lo) - 1));
				end
				default: begin
					top = int'(lo) + int'($urandom_range(1, 600));
					hi = (top > 65535) ? 16'hFFFF : CfgDataW'(top);
				end
			endcase
			case ($urandom_range(3))
				0: sat = '0;
				1: sat = 16'd256;
				2: sat = CfgDataW'($urandom_range(256));
				default: ;
			endcase
			case ($urandom_range(5))
				0: bri = '0;
				1: bri = 16'd255;
				default: ;
			endcase
		end
		write_reg(REG_MIN_RANGE, lo);
		write_reg(REG_MAX_RANGE, hi);
		write_reg(REG_SATURATION, sat);
		write_reg(REG_BRIGHTNESS, bri);
		case (ph % 4)
			0: begin source_idle_pct = 0;  sink_stall_pct = 0;  end
			1: begin source_idle_pct = 61; sink_stall_pct = 0;  end
			2: begin source_idle_pct = 0;  sink_stall_pct = 61; end
			default: begin source_idle_pct = 18; sink_stall_pct = 18; end
		endcase
	endtask

	// Receiver: random back-pressure, and one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				rgb_ready = 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				rgb_ready = ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// Check each output beat against the oldest expected colour
	always @(posedge clk) begin
		rgb_beat_t want;
		if (arst_n && rgb_valid && rgb_ready) begin
			beat_count++;
			if (pending_colours.size() == 0) begin
				report_mismatch("result with nothing pending", rgb_valid, 0);
			end else begin
				want = pending_colours.pop_front();
				if (red !== want.red)
					report_mismatch("red", red, want.red);
				if (green !== want.green)
					report_mismatch("green", green, want.green);
				if (blue !== want.blue)
					report_mismatch("blue", blue, want.blue);
				if (bad_config !== want.bad)
					report_mismatch("bad_config", bad_config, want.bad);
			end
		end
	end

	// Main sequence: reset, directed table, random phases, final verdict
	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (steps[i]) begin
			if (steps[i].kind == ROW_REG) begin
				drain_pipe(PauseCycles);
				write_reg(steps[i].sel, steps[i].value);
			end else begin
				send_pixel(steps[i].value, steps[i].typed, steps[i].want);
			end
		end

		for (int ph = 0; ph < NumPhases; ph++) begin
			start_phase(ph);
			// Hold the receiver off while the sender keeps pushing
			if (ph == 4)
				hold_off_req = 1'b1;
			for (int n = 0; n < PhaseItems; n++)
				send_pixel(pick_index(), 1'b0, '0);
		end

		drain_pipe(EndCycles);
		if (mismatch_count == 0 && pending_colours.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
